### src/hptc_pkg.sv
// ============================================================================
// hptc_pkg - heading PI turn controller shared definitions
// Field widths, command and register codes, fixed timing and divider constants.
// ============================================================================
package hptc_pkg;

    // Field widths
    localparam int ANGLE_W = 25;
    localparam int STEER_W = 12;
    localparam int BAND_W  = 24;
    localparam int LIMIT_W = 11;
    localparam int INTEG_W = 12;
    localparam int WAIT_W  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Stream widths: input tdata carries 55 bits of fields, result tdata 20
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // Request kind carried on s_tuser
    typedef enum logic [1:0] {
        ACT_TICK           = 2'd0,
        ACT_START_TURN     = 2'd1,
        ACT_START_STRAIGHT = 2'd2,
        ACT_DISABLE        = 2'd3
    } action_t;

    // Drive and speed command codes
    localparam logic [1:0] DRV_NONE    = 2'd0;
    localparam logic [1:0] DRV_STOP    = 2'd1;
    localparam logic [1:0] DRV_FORWARD = 2'd2;
    localparam logic [1:0] DRV_REVERSE = 2'd3;

    localparam logic [1:0] SPD_NONE = 2'd0;
    localparam logic [1:0] SPD_SLOW = 2'd1;
    localparam logic [1:0] SPD_FAST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEER_MAX      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_STRAIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_BAND      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BAND      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT    = 3'd5;

    // Register reset values
    localparam logic [STEER_W-1:0] STEER_MAX_RST      = 12'sd400;
    localparam logic [STEER_W-1:0] STEER_MIN_RST      = -12'sd400;
    localparam logic [STEER_W-1:0] STEER_STRAIGHT_RST = 12'sd0;
    localparam logic [BAND_W-1:0]  SLOW_BAND_RST      = 24'd100000;
    localparam logic [BAND_W-1:0]  STOP_BAND_RST      = 24'd20000;
    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST    = 11'd720;

    // Tick counts for the timed waits
    localparam logic [WAIT_W-1:0] STRAIGHT_WAIT_TICKS = 7'd33;
    localparam logic [WAIT_W-1:0] TURN_WAIT_TICKS     = 7'd100;

    // Proportional divisor, done as multiply by a rounded-up reciprocal.
    // |error| < 2^25 and the reciprocal excess times 2^25 stays under
    // 2^P_SHIFT, so the truncated product equals the exact quotient.
    localparam int P_DIV    = 5000;
    localparam int P_SHIFT  = 38;
    localparam int RECIP_W  = 26;
    localparam int QUO_W    = 13;
    localparam int PROD_W   = (ANGLE_W) + RECIP_W;
    localparam logic [RECIP_W-1:0] P_RECIP =
        RECIP_W'(((64'd1 << P_SHIFT) + 64'(P_DIV) - 64'd1) / 64'(P_DIV));

    // Integral output scaling, divide by 8 toward zero
    localparam int I_SHIFT = 3;

endpackage

### src/heading_pi_turn_controller.sv
// An accepted request goes into an input register and then a result register, which
// drives m_tvalid. Throughput: one request per cycle while m_tready keeps the result
// register free; the controller state updates as a request moves between the two
// registers through the error divider multiply and the PI clamp logic.
// Reset: synchronous on aresetn low; clears control state, loads the
// configuration defaults, mode goes to idle-finished.
// ============================================================================
// heading_pi_turn_controller - heading turn and straight PI steering controller
// One result per request of any action: drive, speed, steering and status commands.
// ============================================================================
module heading_pi_turn_controller
    import hptc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [24:0] target_angle, [49:25] heading, [50] bumper_left, [51] bumper_right,
    // [52] sonar_near, [53] sonar_far, [54] driving_forward, [55] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] action
    input  logic [S_TUSER_W-1:0]  s_tuser,

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] drive_cmd, [3:2] speed_cmd, [4] steer_valid, [16:5] steer_pos,
    // [17] ignore_contacts, [18] done_res, [19] running, [23:20] zero
    output logic [M_TDATA_W-1:0]  m_tdata
);

    typedef enum logic [3:0] {
        MODE_STRAIGHT_INIT,
        MODE_STRAIGHT,
        MODE_STRAIGHT_WAIT,
        MODE_TURN_INIT,
        MODE_TURN_WAIT,
        MODE_TURN,
        MODE_TURN_DONE,
        MODE_TO_STRAIGHT,
        MODE_TO_STRAIGHT_WAIT,
        MODE_IDLE
    } mode_t;

    // Configuration registers
    logic [STEER_W-1:0] steer_max_reg, steer_min_reg, steer_straight_reg;
    logic [BAND_W-1:0]  slow_band_reg, stop_band_reg;
    logic [LIMIT_W-1:0] integ_limit_reg;

    // Input stage
    logic                      in_vld_reg;
    action_t                   act_reg;
    logic signed [ANGLE_W-1:0] tgt_in_reg, hdg_in_reg;
    logic                      bl_reg, br_reg, snear_reg, sfar_reg, fwd_reg;

    // Controller state
    mode_t                     mode_reg, mode_next;
    logic                      run_reg, run_next;
    logic signed [ANGLE_W-1:0] target_reg, target_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic [WAIT_W-1:0]         wait_reg, wait_next;

    // Result stage
    logic                      out_vld_reg;
    logic [1:0]                drive_reg, drive_next;
    logic [1:0]                speed_reg, speed_next;
    logic                      svalid_reg, svalid_next;
    logic signed [STEER_W-1:0] spos_reg, spos_next;
    logic                      ignore_reg, ignore_next;
    logic                      done_reg, done_next;
    logic                      running_reg;

    logic out_free, advance;

    // Error path
    logic signed [ANGLE_W-1:0] tgt_eff;
    logic signed [ANGLE_W:0]   err;
    logic [ANGLE_W:0]          err_abs;
    logic [ANGLE_W-1:0]        err_mag;
    logic [PROD_W-1:0]         prod;
    logic [QUO_W-1:0]          quo;
    logic signed [QUO_W:0]     p_val;

    // PI path
    logic                      frozen;
    logic signed [14:0]        integ_sum, integ_sel, lim_pos, lim_neg, integ_cl;
    logic signed [INTEG_W-1:0] integ_new, integ_rnd, integ_div;
    logic signed [14:0]        u_sum, u_max, u_cl;

    // Handshake: input register refills while the result register frees up
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || advance;

    // Heading error and |error| / 5000 by reciprocal multiply
    assign tgt_eff = (act_reg == ACT_START_TURN || act_reg == ACT_START_STRAIGHT)
                     ? tgt_in_reg : target_reg;
    assign err     = {tgt_eff[ANGLE_W-1], tgt_eff} - {hdg_in_reg[ANGLE_W-1], hdg_in_reg};
    assign err_abs = err[ANGLE_W] ? (~err + 1'b1) : err;
    assign err_mag = err_abs[ANGLE_W-1:0];
    assign prod    = PROD_W'(err_mag) * PROD_W'(P_RECIP);
    assign quo     = prod[P_SHIFT +: QUO_W];
    assign p_val   = err[ANGLE_W] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    // Integral: accumulate unless a bumper or sonar_near flag is up, then clamp
    assign frozen    = bl_reg || br_reg || snear_reg;
    assign integ_sum = 15'(integ_reg) + 15'(p_val);
    assign integ_sel = frozen ? 15'(integ_reg) : integ_sum;
    assign lim_pos   = $signed({4'd0, integ_limit_reg});
    assign lim_neg   = -lim_pos;
    assign integ_cl  = (integ_sel > lim_pos) ? lim_pos :
                       (integ_sel < lim_neg) ? lim_neg : integ_sel;
    assign integ_new = integ_cl[INTEG_W-1:0];

    // I/8 toward zero, P + I/8, clamp high first then low
    assign integ_rnd = integ_new + (integ_new[INTEG_W-1] ? 12'sd7 : 12'sd0);
    assign integ_div = integ_rnd >>> I_SHIFT;
    assign u_sum     = 15'(p_val) + 15'(integ_div);
    assign u_max     = (u_sum > 15'($signed(steer_max_reg))) ?
                       15'($signed(steer_max_reg)) : u_sum;
    assign u_cl      = (u_max < 15'($signed(steer_min_reg))) ?
                       15'($signed(steer_min_reg)) : u_max;

    // Command decode and mode step
    always_comb begin
        mode_next   = mode_reg;
        run_next    = run_reg;
        target_next = target_reg;
        integ_next  = integ_reg;
        wait_next   = wait_reg;
        drive_next  = DRV_NONE;
        speed_next  = SPD_NONE;
        svalid_next = 1'b0;
        spos_next   = '0;
        ignore_next = 1'b0;

        case (act_reg)
            ACT_DISABLE: begin
                run_next = 1'b0;
            end
            ACT_START_TURN: begin
                target_next = tgt_in_reg;
                mode_next   = MODE_TURN_INIT;
                run_next    = 1'b1;
            end
            ACT_START_STRAIGHT: begin
                target_next = tgt_in_reg;
                mode_next   = (mode_reg == MODE_TURN_DONE || mode_reg == MODE_TURN)
                              ? MODE_TO_STRAIGHT : MODE_STRAIGHT_INIT;
                run_next    = 1'b1;
            end
            default: begin
            end
        endcase

        if (run_next) begin
            case (mode_next)
                MODE_STRAIGHT_INIT: begin
                    drive_next = DRV_FORWARD;
                    integ_next = '0;
                    mode_next  = MODE_STRAIGHT;
                end
                MODE_STRAIGHT: begin
                    integ_next  = integ_new;
                    svalid_next = 1'b1;
                    spos_next   = u_cl[STEER_W-1:0];
                    mode_next   = MODE_STRAIGHT_WAIT;
                    wait_next   = '0;
                end
                MODE_STRAIGHT_WAIT: begin
                    wait_next = wait_reg + 1'b1;
                    if (wait_next > STRAIGHT_WAIT_TICKS) begin
                        mode_next = MODE_STRAIGHT;
                        wait_next = '0;
                    end
                end
                MODE_TURN_INIT: begin
                    drive_next  = DRV_STOP;
                    svalid_next = 1'b1;
                    spos_next   = steer_max_reg;
                    mode_next   = MODE_TURN_WAIT;
                    wait_next   = '0;
                end
                MODE_TURN_WAIT: begin
                    wait_next = wait_reg + 1'b1;
                    if (wait_next > TURN_WAIT_TICKS) begin
                        drive_next = (err > 0) ? DRV_FORWARD : DRV_REVERSE;
                        mode_next  = MODE_TURN;
                    end
                end
                MODE_TURN: begin
                    speed_next = (err_mag < ANGLE_W'(slow_band_reg)) ? SPD_SLOW : SPD_FAST;
                    if (err_mag < ANGLE_W'(stop_band_reg)) begin
                        drive_next = DRV_STOP;
                        mode_next  = MODE_TURN_DONE;
                        wait_next  = '0;
                    end
                    ignore_next = fwd_reg && (sfar_reg || snear_reg) && !bl_reg && !br_reg;
                end
                MODE_TO_STRAIGHT: begin
                    svalid_next = 1'b1;
                    spos_next   = steer_straight_reg;
                    wait_next   = '0;
                    mode_next   = MODE_TO_STRAIGHT_WAIT;
                end
                MODE_TO_STRAIGHT_WAIT: begin
                    wait_next = wait_reg + 1'b1;
                    if (wait_next > TURN_WAIT_TICKS) begin
                        mode_next = MODE_STRAIGHT_INIT;
                    end
                end
                default: begin
                end
            endcase
        end

        done_next = (mode_next == MODE_IDLE || mode_next == MODE_TURN_DONE);
    end

    // State, configuration and stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steer_max_reg      <= STEER_MAX_RST;
            steer_min_reg      <= STEER_MIN_RST;
            steer_straight_reg <= STEER_STRAIGHT_RST;
            slow_band_reg      <= SLOW_BAND_RST;
            stop_band_reg      <= STOP_BAND_RST;
            integ_limit_reg    <= INTEG_LIMIT_RST;
            in_vld_reg         <= 1'b0;
            out_vld_reg        <= 1'b0;
            mode_reg           <= MODE_IDLE;
            run_reg            <= 1'b0;
            target_reg         <= '0;
            integ_reg          <= '0;
            wait_reg           <= '0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEER_MAX:      steer_max_reg      <= cfg_data[STEER_W-1:0];
                    REG_STEER_MIN:      steer_min_reg      <= cfg_data[STEER_W-1:0];
                    REG_STEER_STRAIGHT: steer_straight_reg <= cfg_data[STEER_W-1:0];
                    REG_SLOW_BAND:      slow_band_reg      <= cfg_data[BAND_W-1:0];
                    REG_STOP_BAND:      stop_band_reg      <= cfg_data[BAND_W-1:0];
                    REG_INTEG_LIMIT:    integ_limit_reg    <= cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // stage valids
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (out_free) begin
                out_vld_reg <= in_vld_reg;
            end

            // controller state moves with each request
            if (advance) begin
                mode_reg   <= mode_next;
                run_reg    <= run_next;
                target_reg <= target_next;
                integ_reg  <= integ_next;
                wait_reg   <= wait_next;
            end
        end

        // input payload
        if (s_tvalid && s_tready) begin
            act_reg    <= action_t'(s_tuser[1:0]);
            tgt_in_reg <= s_tdata[24:0];
            hdg_in_reg <= s_tdata[49:25];
            bl_reg     <= s_tdata[50];
            br_reg     <= s_tdata[51];
            snear_reg  <= s_tdata[52];
            sfar_reg   <= s_tdata[53];
            fwd_reg    <= s_tdata[54];
        end

        // result payload
        if (advance) begin
            drive_reg   <= drive_next;
            speed_reg   <= speed_next;
            svalid_reg  <= svalid_next;
            spos_reg    <= spos_next;
            ignore_reg  <= ignore_next;
            done_reg    <= done_next;
            running_reg <= run_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, running_reg, done_reg, ignore_reg, spos_reg,
                       svalid_reg, speed_reg, drive_reg};

    // Checks
    a_wait_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wait_reg <= TURN_WAIT_TICKS + 7'd1)
        else $error("wait counter ran past the turn wait");

    a_spos_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !svalid_reg) |-> (spos_reg == '0))
        else $error("steering position set without steer_valid");

    a_ignore_in_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && ignore_reg) |-> (speed_reg != SPD_NONE && running_reg))
        else $error("ignore_contacts outside a running turn step");

    a_drive_no_steer: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && (drive_reg == DRV_FORWARD || drive_reg == DRV_REVERSE))
        |-> !svalid_reg)
        else $error("drive direction issued together with a steering update");

endmodule

### tb/heading_pi_turn_controller_tb.sv
// ============================================================================
// heading_pi_turn_controller_tb - self-checking bench for the heading controller
// Streams tick, start and disable requests, keeps a request-level mirror of the
// controller state, and compares every command result field by field.
// Config is rewritten between phases, extremes and inverted steer limits included.
// ============================================================================
module heading_pi_turn_controller_tb;
    import hptc_pkg::*;

    localparam int REQUEST_GOAL  = 1400;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 25'h0FF_FFFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 25'h100_0000;

    // Controller modes as the mirror tracks them
    typedef enum logic [3:0] {
        MD_STRAIGHT_INIT    = 4'd0,
        MD_STRAIGHT         = 4'd2,
        MD_STRAIGHT_WAIT    = 4'd3,
        MD_TURN_INIT        = 4'd4,
        MD_TURN_WAIT        = 4'd5,
        MD_TURN             = 4'd6,
        MD_TURN_DONE        = 4'd7,
        MD_TO_STRAIGHT      = 4'd8,
        MD_TO_STRAIGHT_WAIT = 4'd9,
        MD_IDLE             = 4'd10
    } ctl_mode_t;

    typedef struct packed {
        logic [1:0]         drive;
        logic [1:0]         speed;
        logic               steer_valid;
        logic [STEER_W-1:0] steer_pos;
        logic               ignore_contacts;
        logic               done;
        logic               running;
    } ctl_cmd_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    heading_pi_turn_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mirror of the controller state and its registers
    ctl_mode_t                  pm_mode;
    logic                       pm_running;
    logic signed [ANGLE_W-1:0]  pm_target;
    logic signed [INTEG_W-1:0]  pm_integ;
    logic [WAIT_W-1:0]          pm_wait;
    logic signed [STEER_W-1:0]  cfg_steer_max, cfg_steer_min, cfg_steer_straight;
    logic [BAND_W-1:0]          cfg_slow_band, cfg_stop_band;
    logic [LIMIT_W-1:0]         cfg_integ_limit;

    ctl_cmd_t pending_cmds[$];
    ctl_cmd_t oldest_cmd;

    int  failures        = 0;
    int  active_requests = 0;
    int  total_requests  = 0;
    int  cmds_checked    = 0;
    int  reg_writes      = 0;
    int  turns_done      = 0;
    int  steer_updates   = 0;
    int  ignore_pulses   = 0;
    int  cycle_count     = 0;
    int  burst_left      = 0;
    bit  gaps_on         = 1'b1;

    // Receiver stall pattern: a 16-bit ready mask, redrawn every pass
    logic [15:0] rx_mask  = 16'hFFFF;
    logic [3:0]  rx_phase = 4'd0;

    always @(negedge aclk) begin
        if (rx_phase == 4'd15) begin
            case ($urandom_range(0, 3))
                0: rx_mask <= 16'hFFFF;
                1: rx_mask <= (16'($urandom) & 16'($urandom)) | 16'h8001;
                default: rx_mask <= 16'($urandom) | 16'h0101;
            endcase
        end
        rx_phase <= rx_phase + 4'd1;
        m_tready <= rx_mask[rx_phase];
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d commands outstanding",
                     cycle_count, pending_cmds.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned expv,
                               input int unsigned actv);
        if (expv != actv)
            note_failure($sformatf("%s expected %0d got %0d (result %0d)",
                                   name, expv, actv, cmds_checked));
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                note_failure($sformatf("unexpected result %h", m_tdata));
            end else begin
                oldest_cmd = pending_cmds.pop_front();
                check_field("drive_cmd", oldest_cmd.drive, m_tdata[1:0]);
                check_field("speed_cmd", oldest_cmd.speed, m_tdata[3:2]);
                check_field("steer_valid", oldest_cmd.steer_valid, m_tdata[4]);
                check_field("steer_pos", oldest_cmd.steer_pos, m_tdata[16:5]);
                check_field("ignore_contacts", oldest_cmd.ignore_contacts, m_tdata[17]);
                check_field("done", oldest_cmd.done, m_tdata[18]);
                check_field("running", oldest_cmd.running, m_tdata[19]);
                cmds_checked++;
            end
        end
    end

    // One controller tick: sens = {fwd, sonar_far, sonar_near, bump_right, bump_left}
    task automatic predict_controller_tick(input action_t act,
                                           input logic signed [ANGLE_W-1:0] tgt,
                                           input logic signed [ANGLE_W-1:0] hdg,
                                           input logic [4:0] sens,
                                           output ctl_cmd_t cmd);
        logic signed [26:0] err, sb, pb;
        logic signed [15:0] p, lim, acc, u, smax, smin;
        logic bl, br, snear, sfar, fwd;
        begin
            cmd   = '0;
            bl    = sens[0];
            br    = sens[1];
            snear = sens[2];
            sfar  = sens[3];
            fwd   = sens[4];
            if (act != ACT_TICK ||
                (pm_running && pm_mode != MD_IDLE && pm_mode != MD_TURN_DONE))
                active_requests++;

            case (act)
                ACT_DISABLE: pm_running = 1'b0;
                ACT_START_TURN: begin
                    pm_target  = tgt;
                    pm_mode    = MD_TURN_INIT;
                    pm_running = 1'b1;
                end
                ACT_START_STRAIGHT: begin
                    pm_target  = tgt;
                    pm_mode    = (pm_mode == MD_TURN_DONE || pm_mode == MD_TURN) ?
                                 MD_TO_STRAIGHT : MD_STRAIGHT_INIT;
                    pm_running = 1'b1;
                end
                default: ;
            endcase

            err = 27'(pm_target) - 27'(hdg);

            if (pm_running) begin
                case (pm_mode)
                    MD_STRAIGHT_INIT: begin
                        cmd.drive = DRV_FORWARD;
                        pm_integ  = '0;
                        pm_mode   = MD_STRAIGHT;
                    end
                    MD_STRAIGHT: begin
                        // PI step: integral frozen on a bumper or sonar_near flag
                        p   = 16'(err / 27'sd5000);
                        lim = $signed({5'b00000, cfg_integ_limit});
                        acc = 16'(pm_integ);
                        if (!(bl || br || snear))
                            acc = acc + p;
                        if (acc > lim)
                            acc = lim;
                        if (acc < -lim)
                            acc = -lim;
                        pm_integ = acc[INTEG_W-1:0];
                        u    = p + acc / 16'sd8;
                        smax = 16'(cfg_steer_max);
                        smin = 16'(cfg_steer_min);
                        if (u > smax)
                            u = smax;
                        if (u < smin)
                            u = smin;
                        cmd.steer_valid = 1'b1;
                        cmd.steer_pos   = u[STEER_W-1:0];
                        pm_mode = MD_STRAIGHT_WAIT;
                        pm_wait = '0;
                        steer_updates++;
                    end
                    MD_STRAIGHT_WAIT: begin
                        pm_wait = pm_wait + 7'd1;
                        if (pm_wait > STRAIGHT_WAIT_TICKS) begin
                            pm_mode = MD_STRAIGHT;
                            pm_wait = '0;
                        end
                    end
                    MD_TURN_INIT: begin
                        cmd.drive       = DRV_STOP;
                        cmd.steer_valid = 1'b1;
                        cmd.steer_pos   = cfg_steer_max;
                        pm_mode = MD_TURN_WAIT;
                        pm_wait = '0;
                    end
                    MD_TURN_WAIT: begin
                        pm_wait = pm_wait + 7'd1;
                        if (pm_wait > TURN_WAIT_TICKS) begin
                            cmd.drive = (err > 0) ? DRV_FORWARD : DRV_REVERSE;
                            pm_mode   = MD_TURN;
                        end
                    end
                    MD_TURN: begin
                        sb = $signed({3'b000, cfg_slow_band});
                        pb = $signed({3'b000, cfg_stop_band});
                        cmd.speed = (err < sb && err > -sb) ? SPD_SLOW : SPD_FAST;
                        if (err < pb && err > -pb) begin
                            cmd.drive = DRV_STOP;
                            pm_mode   = MD_TURN_DONE;
                            pm_wait   = '0;
                            turns_done++;
                        end
                        if (fwd && (sfar || snear) && !bl && !br) begin
                            cmd.ignore_contacts = 1'b1;
                            ignore_pulses++;
                        end
                    end
                    MD_TO_STRAIGHT: begin
                        cmd.steer_valid = 1'b1;
                        cmd.steer_pos   = cfg_steer_straight;
                        pm_wait = '0;
                        pm_mode = MD_TO_STRAIGHT_WAIT;
                    end
                    MD_TO_STRAIGHT_WAIT: begin
                        pm_wait = pm_wait + 7'd1;
                        if (pm_wait > TURN_WAIT_TICKS)
                            pm_mode = MD_STRAIGHT_INIT;
                    end
                    default: ;
                endcase
            end

            cmd.done    = (pm_mode == MD_IDLE || pm_mode == MD_TURN_DONE);
            cmd.running = pm_running;
        end
    endtask

    // Send one request; with gaps on, the sender idles between bursts of random length
    task automatic send_request(input action_t act,
                                input logic signed [ANGLE_W-1:0] tgt,
                                input logic signed [ANGLE_W-1:0] hdg,
                                input logic [4:0] sens);
        int gap;
        ctl_cmd_t cmd;
        begin
            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if (gaps_on)
                    gap = $urandom_range(1, 8);
            end
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end else begin
                @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {1'b0, sens, hdg, tgt};
            s_tuser  <= act;
            do @(posedge aclk); while (s_tready !== 1'b1);
            predict_controller_tick(act, tgt, hdg, sens, cmd);
            pending_cmds.push_back(cmd);
            burst_left--;
            total_requests++;
        end
    endtask

    // Drain: all results in and the pipeline settled
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_STEER_MAX:      cfg_steer_max      = val[STEER_W-1:0];
            REG_STEER_MIN:      cfg_steer_min      = val[STEER_W-1:0];
            REG_STEER_STRAIGHT: cfg_steer_straight = val[STEER_W-1:0];
            REG_SLOW_BAND:      cfg_slow_band      = val[BAND_W-1:0];
            REG_STOP_BAND:      cfg_stop_band      = val[BAND_W-1:0];
            REG_INTEG_LIMIT:    cfg_integ_limit    = val[LIMIT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_all_regs(input int smax, input int smin, input int sstr,
                                  input int slow, input int stop, input int lim);
        write_reg(REG_STEER_MAX, CFG_DATA_W'(smax));
        write_reg(REG_STEER_MIN, CFG_DATA_W'(smin));
        write_reg(REG_STEER_STRAIGHT, CFG_DATA_W'(sstr));
        write_reg(REG_SLOW_BAND, CFG_DATA_W'(slow));
        write_reg(REG_STOP_BAND, CFG_DATA_W'(stop));
        write_reg(REG_INTEG_LIMIT, CFG_DATA_W'(lim));
    endtask

    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        return ANGLE_W'($urandom);
    endfunction

    function automatic logic [4:0] rand_sens();
        return 5'($urandom);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] clamp_angle(input longint v);
        if (v > longint'(ANGLE_MAX))
            return ANGLE_MAX;
        if (v < longint'(ANGLE_MIN))
            return ANGLE_MIN;
        return v[ANGLE_W-1:0];
    endfunction

    function automatic int pick_steer();
        case ($urandom_range(0, 4))
            0: return -2048;
            1: return 2047;
            2: return $urandom_range(0, 1000) - 500;
            default: return int'($signed(12'($urandom)));
        endcase
    endfunction

    function automatic int pick_band();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 24'hFF_FFFF;
            2: return $urandom_range(0, 300000);
            default: return int'(24'($urandom));
        endcase
    endfunction

    // Turn: full-lock wait, then approach the target through the bands
    task automatic run_turn(input bit zero_err);
        logic signed [ANGLE_W-1:0] tgt, hdg;
        longint mag, step;
        bit dir;
        int steps;
        begin
            if ($urandom_range(0, 7) == 0)
                tgt = $urandom_range(0, 1) ? ANGLE_MAX : ANGLE_MIN;
            else
                tgt = rand_angle();
            send_request(ACT_START_TURN, tgt, rand_angle(), rand_sens());
            while (pm_mode == MD_TURN_WAIT) begin
                // heading equal to target on the deciding tick gives zero error
                hdg = (zero_err && pm_wait == TURN_WAIT_TICKS) ? tgt : rand_angle();
                send_request(ACT_TICK, rand_angle(), hdg, rand_sens());
            end
            mag  = (cfg_slow_band > cfg_stop_band) ? longint'(cfg_slow_band) :
                                                     longint'(cfg_stop_band);
            mag  = mag + $urandom_range(1, 200000);
            step = mag / 15 + 1;
            dir  = $urandom_range(0, 1);
            steps = 0;
            while (pm_mode == MD_TURN && steps < 40) begin
                hdg = clamp_angle(longint'(tgt) - (dir ? mag : -mag));
                send_request(ACT_TICK, rand_angle(), hdg, rand_sens());
                mag = (mag > step) ? mag - step : 0;
                steps++;
            end
            repeat ($urandom_range(0, 3))
                send_request(ACT_TICK, rand_angle(), rand_angle(), rand_sens());
        end
    endtask

    // Straight: PI loop with heading errors of a random spread
    task automatic run_straight(input int n_ticks);
        logic signed [ANGLE_W-1:0] tgt;
        longint spread, err;
        logic [4:0] obst_mask;
        begin
            tgt = rand_angle();
            case ($urandom_range(0, 3))
                0: spread = 2000;
                1: spread = 200000;
                2: spread = 4000000;
                default: spread = 64'd1 << 24;
            endcase
            obst_mask = $urandom_range(0, 1) ? 5'h18 : 5'h1F;
            send_request(ACT_START_STRAIGHT, tgt, rand_angle(), rand_sens());
            repeat (n_ticks) begin
                err = longint'($urandom_range(0, 2 * spread)) - spread;
                send_request(ACT_TICK, rand_angle(), clamp_angle(longint'(tgt) - err),
                             rand_sens() & obst_mask);
            end
        end
    endtask

    task automatic run_noise(input int n);
        repeat (n)
            send_request(action_t'($urandom_range(0, 3)), rand_angle(), rand_angle(),
                         rand_sens());
    endtask

    // Sequences cut short by a disable, a new start or noise
    task automatic run_interrupted();
        send_request($urandom_range(0, 1) ? ACT_START_TURN : ACT_START_STRAIGHT,
                     rand_angle(), rand_angle(), rand_sens());
        repeat ($urandom_range(0, 40))
            send_request(ACT_TICK, rand_angle(), rand_angle(), rand_sens());
        case ($urandom_range(0, 2))
            0: begin
                send_request(ACT_DISABLE, rand_angle(), rand_angle(), rand_sens());
                repeat ($urandom_range(1, 6))
                    send_request(ACT_TICK, rand_angle(), rand_angle(), rand_sens());
            end
            1: send_request($urandom_range(0, 1) ? ACT_START_TURN : ACT_START_STRAIGHT,
                            rand_angle(), rand_angle(), rand_sens());
            default: run_noise($urandom_range(2, 8));
        endcase
    endtask

    task automatic apply_random_config();
        wait_idle();
        write_all_regs(pick_steer(), pick_steer(), pick_steer(), pick_band(), pick_band(),
                       $urandom_range(0, 3) == 0 ? 2047 : $urandom_range(0, 2047));
    endtask

    // Field extremes, every action, idle and disabled ticks, inverted limits
    task automatic test_directed_basics();
        send_request(ACT_TICK, ANGLE_MAX, ANGLE_MIN, 5'h1F);
        send_request(ACT_DISABLE, ANGLE_MIN, ANGLE_MAX, 5'h00);
        send_request(ACT_TICK, '0, '0, 5'h00);
        send_request(ACT_START_STRAIGHT, ANGLE_MAX, ANGLE_MIN, 5'h00);
        send_request(ACT_TICK, ANGLE_MIN, ANGLE_MIN, 5'h00);
        send_request(ACT_START_STRAIGHT, ANGLE_MIN, ANGLE_MAX, 5'h1F);
        send_request(ACT_TICK, '0, ANGLE_MAX, 5'h1F);
        send_request(ACT_START_TURN, ANGLE_MAX, ANGLE_MAX, 5'h15);
        send_request(ACT_TICK, ANGLE_MIN, '0, 5'h0A);
        // straight start from the turn wait skips the re-center step
        send_request(ACT_START_STRAIGHT, 25'sd20000, '0, 5'h0A);
        send_request(ACT_TICK, '0, '0, 5'h03);
        send_request(ACT_DISABLE, '0, '0, 5'h00);
        send_request(ACT_TICK, ANGLE_MAX, ANGLE_MAX, 5'h1F);
        send_request(ACT_TICK, ANGLE_MIN, ANGLE_MIN, 5'h10);
        wait_idle();
        // inverted limits: the lower bound wins
        write_reg(REG_STEER_MAX, CFG_DATA_W'(-100));
        write_reg(REG_STEER_MIN, CFG_DATA_W'(100));
        send_request(ACT_START_STRAIGHT, '0, '0, 5'h00);
        send_request(ACT_TICK, '0, 25'sd250000, 5'h00);
        send_request(ACT_START_TURN, 25'sd1000, '0, 5'h00);
        send_request(ACT_TICK, '0, '0, 5'h00);
        wait_idle();
        write_all_regs(400, -400, 0, 100000, 20000, 720);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_all_regs(2047, -2048, -2048, 24'hFF_FFFF, 0, 2047);
        run_straight(80);
        run_turn(1'b0);
        wait_idle();
        write_all_regs(-2048, 2047, 2047, 0, 24'hFF_FFFF, 0);
        run_turn(1'b0);
        run_straight(140);
        wait_idle();
        write_all_regs(400, -400, 0, 100000, 20000, 720);
    endtask

    task automatic test_turn_zero_error();
        run_turn(1'b1);
    endtask

    // Straight start from a finished turn re-centers and waits first
    task automatic test_straight_after_turn();
        run_turn(1'b0);
        run_straight(150);
    endtask

    task automatic test_random_traffic();
        int pick;
        begin
            while (active_requests < REQUEST_GOAL) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    apply_random_config();
                end else if (pick < 30) begin
                    run_turn($urandom_range(0, 9) == 0);
                    if ($urandom_range(0, 2) == 0)
                        run_straight($urandom_range(110, 160));
                end else if (pick < 60) begin
                    run_straight($urandom_range(20, 120));
                end else if (pick < 80) begin
                    run_interrupted();
                end else begin
                    run_noise($urandom_range(3, 20));
                end
            end
        end
    endtask

    initial begin
        pm_mode            = MD_IDLE;
        pm_running         = 1'b0;
        pm_target          = '0;
        pm_integ           = '0;
        pm_wait            = '0;
        cfg_steer_max      = STEER_MAX_RST;
        cfg_steer_min      = STEER_MIN_RST;
        cfg_steer_straight = STEER_STRAIGHT_RST;
        cfg_slow_band      = SLOW_BAND_RST;
        cfg_stop_band      = STOP_BAND_RST;
        cfg_integ_limit    = INTEG_LIMIT_RST;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_basics();
        test_register_extremes();
        test_turn_zero_error();
        test_straight_after_turn();
        test_random_traffic();

        wait_idle();
        if (pending_cmds.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_cmds.size()));

        $display("Covered %0d requests (%0d active), %0d results checked, %0d register writes",
                 total_requests, active_requests, cmds_checked, reg_writes);
        $display("Turns finished %0d, straight-loop steer updates %0d, ignore pulses %0d",
                 turns_done, steer_updates, ignore_pulses);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
